FILE: hdl/block_energy_utterance_segmenter_macros.svh
// Assertion macros for the block energy utterance segmenter.
// Used by modules that carry concurrent checks; expects clk and arst_n in scope.
`ifndef BLOCK_ENERGY_UTTERANCE_SEGMENTER_MACROS_SVH
`define BLOCK_ENERGY_UTTERANCE_SEGMENTER_MACROS_SVH
`ifndef SYNTHESIS
`define BEUS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define BEUS_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define BEUS_ASSERT(label, prop, msg)
`define BEUS_NEVER(label, cond, msg)
`endif
`endif

FILE: hdl/beus_pkg.sv
// Shared types, widths and constants of the block energy utterance segmenter.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
package beus_pkg;

	localparam int unsigned MAX_BLOCK_LEN   = 4096;
	localparam int unsigned SAMPLE_BITS_DEF = 16;

	localparam int unsigned SAMPLE_W  = 16;
	localparam int unsigned LEN_W     = 13;
	localparam int unsigned THR_W     = 15;
	localparam int unsigned PAD_W     = 16;
	localparam int unsigned HL_W      = 24;
	localparam int unsigned ENERGY_W  = 43;
	localparam int unsigned NUM_W     = 32;
	localparam int unsigned UTT_W     = 16;
	localparam int unsigned KEPT_W    = 32;
	localparam int unsigned THR_LEN_W = 2 * THR_W + LEN_W;
	localparam int unsigned START_W   = HL_W + 1;

	localparam int unsigned ADDR_W      = 5;
	localparam int unsigned DATA_W      = 32;
	localparam int unsigned TDATA_OUT_W = 144;

	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam logic [ENERGY_W-1:0] E_MAX     = '1;
	localparam logic [START_W-1:0]  START_SAT = {1'b1, {HL_W{1'b0}}};

	localparam logic [LEN_W-1:0] RST_BLOCK_LEN    = 13'd200;
	localparam logic [THR_W-1:0] RST_THRESHOLD    = 15'd20;
	localparam logic [PAD_W-1:0] RST_PAD_LEN      = 16'd2000;
	localparam logic [HL_W-1:0]  RST_HEAD_SAMPLES = 24'd80000;

	localparam logic KIND_VERDICT = 1'b0;
	localparam logic KIND_CLOSE   = 1'b1;

	typedef enum logic [2:0] {
		REG_BLOCK_LEN    = 3'd0,
		REG_THRESHOLD    = 3'd1,
		REG_PAD_LEN      = 3'd2,
		REG_SPLIT        = 3'd3,
		REG_HEAD_EN      = 3'd4,
		REG_HEAD_SAMPLES = 3'd5
	} beus_reg_t;

	typedef enum logic {
		EVT_JUDGE = 1'b0,
		EVT_EOS   = 1'b1
	} beus_evt_kind_t;

	typedef enum logic [1:0] {
		BK_RUN  = 2'd0,
		BK_DIV  = 2'd1,
		BK_DONE = 2'd2
	} beus_bk_state_t;

	typedef struct packed {
		beus_evt_kind_t      kind;
		logic [NUM_W-1:0]    num;
		logic [ENERGY_W-1:0] energy;
	} beus_evt_t;

	typedef struct packed {
		logic [LEN_W-1:0]     len;
		logic [THR_LEN_W-1:0] thr_len;
		logic [PAD_W-1:0]     pad_len;
		logic                 split;
		logic                 hl_en;
		logic [HL_W-1:0]      hl_samples;
		logic                 busy;
	} beus_cfg_t;

	typedef struct packed {
		logic                kind;
		logic [NUM_W-1:0]    num;
		logic [ENERGY_W-1:0] energy;
		logic                speech;
		logic                opens;
		logic                keep;
		logic                closes;
		logic [UTT_W-1:0]    idx;
		logic [PAD_W-1:0]    pad;
		logic [KEPT_W-1:0]   kept;
	} beus_res_t;

	function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] r);
		logic [LEN_W-1:0] l;
		if (r == '0) begin
			l = LEN_W'(1);
		end else if (32'(r) > MAX_BLOCK_LEN) begin
			l = LEN_W'(MAX_BLOCK_LEN);
		end else begin
			l = r;
		end
		return l;
	endfunction

endpackage

FILE: hdl/block_energy_utterance_segmenter.sv
// Top level of the block energy utterance segmenter: config, front end, queue, back end.
// Depends on beus_pkg, beus_cfg, beus_front, beus_fifo and beus_back.
//
// channel | dir | handshake              | payload
// s_      | in  | s_tvalid / s_tready    | s_tdata sample, s_tlast end of stream
// m_      | out | m_tvalid / m_tready    | m_tdata verdict fields, m_tuser kind, m_tlast close
// apb     | in  | psel & penable, pready | register write / read
//
// One sample per cycle while s_tready is high; the square is registered, then the block sum.
// A closing result runs the pad remainder unit, then loads the output register.
// After reset or any register write the input holds off while products settle.
// The queue absorbs front-end requests while the back end or the output stalls.
`timescale 1ns / 1ps
module block_energy_utterance_segmenter #(
	parameter int unsigned SAMPLE_BITS = beus_pkg::SAMPLE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [beus_pkg::SAMPLE_W-1:0]    s_tdata,  // [15:0] sample
	input  logic                             s_tlast,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [31:0] block_number, [74:32] block_energy, [75] is_speech, [76] utterance_opens,
	// [77] keep_block, [93:78] utterance_index, [109:94] pad_count, [141:110] kept_samples
	output logic [beus_pkg::TDATA_OUT_W-1:0] m_tdata,
	output logic                             m_tuser,  // [0] result_kind
	output logic                             m_tlast,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [beus_pkg::ADDR_W-1:0]      paddr,
	input  logic [beus_pkg::DATA_W-1:0]      pwdata,
	output logic [beus_pkg::DATA_W-1:0]      prdata,
	output logic                             pready
);

	beus_pkg::beus_cfg_t cfg;
	beus_pkg::beus_evt_t push_data;
	beus_pkg::beus_evt_t head;
	logic                push;
	logic                pop;
	logic                full;
	logic                empty;

	beus_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	beus_front #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.fifo_full (full),
		.push      (push),
		.push_data (push_data)
	);

	beus_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.full      (full),
		.empty     (empty)
	);

	beus_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.fifo_empty (empty),
		.evt        (head),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule

FILE: hdl/beus_cfg.sv
// Configuration register file with APB-style access and derived thresholds.
// Depends on beus_pkg.
`timescale 1ns / 1ps
module beus_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [beus_pkg::ADDR_W-1:0]  paddr,
	input  logic [beus_pkg::DATA_W-1:0]  pwdata,
	output logic [beus_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	output beus_pkg::beus_cfg_t          cfg
);

	logic [beus_pkg::LEN_W-1:0]       blk_len_q;
	logic [beus_pkg::THR_W-1:0]       thr_q;
	logic [beus_pkg::PAD_W-1:0]       pad_q;
	logic                             split_q;
	logic                             hl_en_q;
	logic [beus_pkg::HL_W-1:0]        hl_q;
	logic [2*beus_pkg::THR_W-1:0]     thr_sq_q;
	logic [beus_pkg::THR_LEN_W-1:0]   thr_len_q;
	logic [1:0]                       busy_q;
	logic [beus_pkg::LEN_W-1:0]       len;
	logic                             wr;
	beus_pkg::beus_reg_t              reg_idx;

	assign pready  = 1'b1;
	assign wr      = psel & penable & pwrite;
	assign reg_idx = beus_pkg::beus_reg_t'(paddr[4:2]);
	assign len     = beus_pkg::eff_len(blk_len_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_len_q <= beus_pkg::RST_BLOCK_LEN;
			thr_q     <= beus_pkg::RST_THRESHOLD;
			pad_q     <= beus_pkg::RST_PAD_LEN;
			split_q   <= 1'b0;
			hl_en_q   <= 1'b0;
			hl_q      <= beus_pkg::RST_HEAD_SAMPLES;
			busy_q    <= 2'd2;
		end else begin
			if (wr) begin
				busy_q <= 2'd2;
			end else if (busy_q != 2'd0) begin
				busy_q <= busy_q - 2'd1;
			end
			if (wr) begin
				case (reg_idx)
					beus_pkg::REG_BLOCK_LEN:    blk_len_q <= pwdata[beus_pkg::LEN_W-1:0];
					beus_pkg::REG_THRESHOLD:    thr_q     <= pwdata[beus_pkg::THR_W-1:0];
					beus_pkg::REG_PAD_LEN:      pad_q     <= pwdata[beus_pkg::PAD_W-1:0];
					beus_pkg::REG_SPLIT:        split_q   <= pwdata[0];
					beus_pkg::REG_HEAD_EN:      hl_en_q   <= pwdata[0];
					beus_pkg::REG_HEAD_SAMPLES: hl_q      <= pwdata[beus_pkg::HL_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// threshold^2 * length, two multiplies with a register between
	always_ff @(posedge clk) begin
		thr_sq_q  <= (2*beus_pkg::THR_W)'(thr_q) * (2*beus_pkg::THR_W)'(thr_q);
		thr_len_q <= beus_pkg::THR_LEN_W'(thr_sq_q) * beus_pkg::THR_LEN_W'(len);
	end

	always_comb begin
		case (reg_idx)
			beus_pkg::REG_BLOCK_LEN:    prdata = beus_pkg::DATA_W'(blk_len_q);
			beus_pkg::REG_THRESHOLD:    prdata = beus_pkg::DATA_W'(thr_q);
			beus_pkg::REG_PAD_LEN:      prdata = beus_pkg::DATA_W'(pad_q);
			beus_pkg::REG_SPLIT:        prdata = beus_pkg::DATA_W'(split_q);
			beus_pkg::REG_HEAD_EN:      prdata = beus_pkg::DATA_W'(hl_en_q);
			beus_pkg::REG_HEAD_SAMPLES: prdata = beus_pkg::DATA_W'(hl_q);
			default:                    prdata = '0;
		endcase
	end

	always_comb begin
		cfg.len        = len;
		cfg.thr_len    = thr_len_q;
		cfg.pad_len    = pad_q;
		cfg.split      = split_q;
		cfg.hl_en      = hl_en_q;
		cfg.hl_samples = hl_q;
		cfg.busy       = (busy_q != 2'd0);
	end

endmodule

FILE: hdl/beus_front.sv
// Front end: accepts samples, accumulates block energy, tracks head limit and
// issues block verdict and end-of-stream requests to the queue. Depends on beus_pkg.
`timescale 1ns / 1ps
module beus_front #(
	parameter int unsigned SAMPLE_BITS = beus_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  beus_pkg::beus_cfg_t           cfg,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [beus_pkg::SAMPLE_W-1:0] s_tdata,
	input  logic                          s_tlast,
	input  logic                          fifo_full,
	output logic                          push,
	output beus_pkg::beus_evt_t           push_data
);

	localparam int unsigned SQ_W   = 2 * SAMPLE_BITS;
	localparam int unsigned ACC_W  = ((SQ_W > beus_pkg::ENERGY_W) ? SQ_W : beus_pkg::ENERGY_W) + 1;
	localparam int unsigned PROD_W = beus_pkg::NUM_W + beus_pkg::LEN_W;

	logic [SAMPLE_BITS-1:0]           raw;
	logic [SAMPLE_BITS-1:0]           mag;
	logic [SQ_W-1:0]                  sq_s1;
	logic                             v_s1;
	logic                             cmpl_s1;
	logic [beus_pkg::ENERGY_W-1:0]    energy_q;
	logic [beus_pkg::ENERGY_W-1:0]    held_e_q;
	logic [ACC_W-1:0]                 sum_wide;
	logic [beus_pkg::ENERGY_W-1:0]    sum_sat;
	logic [beus_pkg::ENERGY_W-1:0]    held_val;
	logic [beus_pkg::LEN_W-1:0]       pos_q;
	logic [beus_pkg::LEN_W:0]         pos_inc;
	logic                             done_blk;
	logic [beus_pkg::NUM_W-1:0]       blocks_q;
	logic [beus_pkg::START_W-1:0]     start_q;
	logic [beus_pkg::START_W:0]       start_add;
	logic [beus_pkg::START_W-1:0]     start_next;
	logic [PROD_W-1:0]                start_prod;
	logic [beus_pkg::START_W-1:0]     start_reload;
	logic                             held_q;
	logic                             head_q;
	logic                             head_hit;
	logic                             accept;
	logic                             take;

	generate
		if (SAMPLE_BITS <= beus_pkg::SAMPLE_W) begin : g_trunc
			assign raw = s_tdata[SAMPLE_BITS-1:0];
		end else begin : g_ext
			assign raw = {{(SAMPLE_BITS - beus_pkg::SAMPLE_W){1'b0}}, s_tdata};
		end
	endgenerate

	assign mag = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;

	assign s_tready = !cfg.busy && !fifo_full;
	assign accept   = s_tvalid & s_tready;

	assign sum_wide = ACC_W'(energy_q) + ACC_W'(sq_s1);
	assign sum_sat  = (sum_wide > ACC_W'(beus_pkg::E_MAX)) ? beus_pkg::E_MAX
	                                                       : sum_wide[beus_pkg::ENERGY_W-1:0];
	// block completed by the sample still in stage 1
	assign held_val = (v_s1 && cmpl_s1) ? sum_sat : held_e_q;

	assign pos_inc  = {1'b0, pos_q} + 1'b1;
	assign done_blk = pos_inc >= {1'b0, cfg.len};

	assign head_hit = cfg.hl_en && (start_q >= beus_pkg::START_W'(cfg.hl_samples));

	assign start_add  = {1'b0, start_q} + (beus_pkg::START_W+1)'(cfg.len);
	assign start_next = (start_add > (beus_pkg::START_W+1)'(beus_pkg::START_SAT))
	                    ? beus_pkg::START_SAT : start_add[beus_pkg::START_W-1:0];
	assign start_prod   = PROD_W'(blocks_q) * PROD_W'(cfg.len);
	assign start_reload = (start_prod > PROD_W'(beus_pkg::START_SAT))
	                      ? beus_pkg::START_SAT : start_prod[beus_pkg::START_W-1:0];

	assign push = accept && (s_tlast || (!head_q && held_q && !head_hit));
	// sample that is accumulated
	assign take = accept && !s_tlast && !head_q && !(held_q && head_hit);

	always_comb begin
		push_data.kind   = s_tlast ? beus_pkg::EVT_EOS : beus_pkg::EVT_JUDGE;
		push_data.num    = blocks_q;
		push_data.energy = s_tlast ? '0 : held_val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			energy_q <= '0;
			pos_q    <= '0;
			blocks_q <= '0;
			start_q  <= '0;
			held_q   <= 1'b0;
			head_q   <= 1'b0;
		end else begin
			v_s1 <= take;
			if (accept && s_tlast) begin
				energy_q <= '0;
			end else if (v_s1) begin
				energy_q <= cmpl_s1 ? '0 : sum_sat;
			end
			if (cfg.busy) begin
				start_q <= start_reload;
			end else if (accept && s_tlast) begin
				start_q <= '0;
			end else if (take && held_q) begin
				start_q <= start_next;
			end
			if (accept && s_tlast) begin
				pos_q    <= '0;
				blocks_q <= '0;
				held_q   <= 1'b0;
				head_q   <= 1'b0;
			end else if (accept && !head_q) begin
				if (held_q && head_hit) begin
					head_q <= 1'b1;
					held_q <= 1'b0;
				end else begin
					if (held_q) begin
						blocks_q <= (blocks_q == '1) ? blocks_q : blocks_q + 1'b1;
					end
					held_q <= done_blk;
					if (done_blk) begin
						pos_q <= '0;
					end else begin
						pos_q <= pos_inc[beus_pkg::LEN_W-1:0];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sq_s1   <= SQ_W'(mag) * SQ_W'(mag);
			cmpl_s1 <= done_blk;
		end
		if (v_s1 && cmpl_s1) begin
			held_e_q <= sum_sat;
		end
	end

endmodule

FILE: hdl/beus_fifo.sv
// Short request queue between front end and back end.
// Depends on beus_pkg.
`timescale 1ns / 1ps
module beus_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  beus_pkg::beus_evt_t push_data,
	input  logic                pop,
	output beus_pkg::beus_evt_t head,
	output logic                full,
	output logic                empty
);

	beus_pkg::beus_evt_t                mem_q [beus_pkg::FIFO_DEPTH];
	logic [beus_pkg::FIFO_PTR_W-1:0]    wr_ptr_q;
	logic [beus_pkg::FIFO_PTR_W-1:0]    rd_ptr_q;
	logic [beus_pkg::FIFO_CNT_W-1:0]    cnt_q;

	assign full  = (cnt_q == beus_pkg::FIFO_CNT_W'(beus_pkg::FIFO_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

FILE: hdl/beus_back.sv
// Back end: utterance state, verdicts, pad remainder unit and output register.
// Depends on beus_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "block_energy_utterance_segmenter_macros.svh"
module beus_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  beus_pkg::beus_cfg_t              cfg,
	input  logic                             fifo_empty,
	input  beus_pkg::beus_evt_t              evt,
	output logic                             pop,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [beus_pkg::TDATA_OUT_W-1:0] m_tdata,
	output logic                             m_tuser,
	output logic                             m_tlast
);

	beus_pkg::beus_bk_state_t          state_q;
	beus_pkg::beus_bk_state_t          state_n;
	logic                              in_utt_q;
	logic [beus_pkg::UTT_W-1:0]        utt_q;
	logic [beus_pkg::KEPT_W-1:0]       kept_q;
	beus_pkg::beus_res_t               res_n;
	beus_pkg::beus_res_t               res_q;
	beus_pkg::beus_res_t               res_pad;
	beus_pkg::beus_res_t               out_q;
	logic                              out_vld_q;
	logic                              out_free;
	logic                              emit_n;
	logic                              div_n;
	logic                              in_utt_n;
	logic [beus_pkg::UTT_W-1:0]        utt_n;
	logic [beus_pkg::KEPT_W-1:0]       kept_n;
	logic                              speech;
	logic                              opens;
	logic [beus_pkg::KEPT_W-1:0]       kept_base;
	logic [beus_pkg::KEPT_W:0]         kept_sum;
	logic [beus_pkg::KEPT_W-1:0]       kept_add;
	logic [beus_pkg::UTT_W-1:0]        utt_inc;
	logic [beus_pkg::UTT_W-1:0]        idx_open;
	logic [beus_pkg::UTT_W-1:0]        idx_cur;
	logic [beus_pkg::PAD_W-1:0]        p_eff;
	logic [beus_pkg::PAD_W-1:0]        rem_q;
	logic [beus_pkg::PAD_W:0]          rem_t;
	logic [beus_pkg::KEPT_W-1:0]       dvd_q;
	logic [4:0]                        cnt_q;
	logic [beus_pkg::PAD_W-1:0]        pad_val;
	logic                              load_evt;
	logic                              start_div;
	logic                              load_pad;

	assign out_free = !out_vld_q || m_tready;

	assign speech    = beus_pkg::THR_LEN_W'(evt.energy) >= cfg.thr_len;
	assign opens     = speech && !in_utt_q;
	assign kept_base = opens ? '0 : kept_q;
	assign kept_sum  = {1'b0, kept_base} + (beus_pkg::KEPT_W+1)'(cfg.len);
	assign kept_add  = kept_sum[beus_pkg::KEPT_W] ? '1 : kept_sum[beus_pkg::KEPT_W-1:0];
	assign utt_inc   = (opens && utt_q != '1) ? utt_q + 1'b1 : utt_q;
	assign idx_open  = (utt_inc == '0) ? '0 : utt_inc - 1'b1;
	assign idx_cur   = (utt_q == '0) ? '0 : utt_q - 1'b1;

	always_comb begin
		res_n    = '0;
		emit_n   = 1'b0;
		div_n    = 1'b0;
		in_utt_n = in_utt_q;
		utt_n    = utt_q;
		kept_n   = kept_q;
		if (evt.kind == beus_pkg::EVT_EOS) begin
			if (in_utt_q) begin
				emit_n       = 1'b1;
				div_n        = 1'b1;
				res_n.kind   = beus_pkg::KIND_CLOSE;
				res_n.closes = 1'b1;
				res_n.idx    = idx_cur;
				res_n.kept   = kept_q;
			end
			in_utt_n = 1'b0;
			utt_n    = '0;
			kept_n   = '0;
		end else begin
			emit_n       = 1'b1;
			res_n.kind   = beus_pkg::KIND_VERDICT;
			res_n.num    = evt.num;
			res_n.energy = evt.energy;
			res_n.speech = speech;
			if (speech) begin
				res_n.opens = opens;
				res_n.keep  = 1'b1;
				res_n.idx   = idx_open;
				res_n.kept  = kept_add;
				in_utt_n    = 1'b1;
				utt_n       = utt_inc;
				kept_n      = kept_add;
			end else if (in_utt_q) begin
				res_n.idx  = idx_cur;
				res_n.kept = kept_q;
				if (cfg.split) begin
					res_n.closes = 1'b1;
					div_n        = 1'b1;
					in_utt_n     = 1'b0;
				end
			end
		end
	end

	// pad remainder, one quotient bit per cycle
	assign p_eff   = (cfg.pad_len == '0) ? beus_pkg::PAD_W'(1) : cfg.pad_len;
	assign rem_t   = {rem_q, dvd_q[beus_pkg::KEPT_W-1]};
	assign pad_val = (rem_q == '0) ? '0 : p_eff - rem_q;

	always_comb begin
		res_pad     = res_q;
		res_pad.pad = pad_val;
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			beus_pkg::BK_RUN:  if (start_div) state_n = beus_pkg::BK_DIV;
			beus_pkg::BK_DIV:  if (cnt_q == '0) state_n = beus_pkg::BK_DONE;
			beus_pkg::BK_DONE: if (out_free) state_n = beus_pkg::BK_RUN;
			default:           state_n = beus_pkg::BK_RUN;
		endcase
	end

	always_comb begin
		pop       = (state_q == beus_pkg::BK_RUN) && !fifo_empty && out_free;
		load_evt  = pop && emit_n && !div_n;
		start_div = pop && emit_n && div_n;
		load_pad  = (state_q == beus_pkg::BK_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= beus_pkg::BK_RUN;
			in_utt_q  <= 1'b0;
			utt_q     <= '0;
			kept_q    <= '0;
			out_vld_q <= 1'b0;
			cnt_q     <= '0;
		end else begin
			state_q <= state_n;
			if (pop) begin
				in_utt_q <= in_utt_n;
				utt_q    <= utt_n;
				kept_q   <= kept_n;
			end
			if (start_div) begin
				cnt_q <= 5'd31;
			end else if (state_q == beus_pkg::BK_DIV) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (load_evt || load_pad) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_div) begin
			res_q <= res_n;
			rem_q <= '0;
			dvd_q <= res_n.kept;
		end else if (state_q == beus_pkg::BK_DIV) begin
			rem_q <= (rem_t >= {1'b0, p_eff}) ? beus_pkg::PAD_W'(rem_t - {1'b0, p_eff})
			                                  : rem_t[beus_pkg::PAD_W-1:0];
			dvd_q <= dvd_q << 1;
		end
		if (load_evt) begin
			out_q <= res_n;
		end else if (load_pad) begin
			out_q <= res_pad;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = out_q.kind;
	assign m_tlast  = out_q.closes;
	assign m_tdata  = {2'b00, out_q.kept, out_q.pad, out_q.idx, out_q.keep, out_q.opens,
	                   out_q.speech, out_q.energy, out_q.num};

	`BEUS_ASSERT(a_open_is_kept_speech, (out_vld_q && out_q.opens) |-> (out_q.speech && out_q.keep), "opening block not kept speech")
	`BEUS_NEVER(a_close_report_closes, out_vld_q && out_q.kind == beus_pkg::KIND_CLOSE && !out_q.closes, "close report without close")
	`BEUS_ASSERT(a_kept_nonzero, (out_vld_q && out_q.keep) |-> (out_q.kept != '0), "kept block with zero length")
	`BEUS_ASSERT(a_eos_clears, (pop && evt.kind == beus_pkg::EVT_EOS) |=> (!in_utt_q && utt_q == '0), "stream end left utterance state")

endmodule

FILE: tb/segmenter_verdict_checker.sv
// Checker for the block energy utterance segmenter: watches the sample, result and register
// ports, predicts block verdicts and close reports, and compares them in order.
// Depends on beus_pkg only.
`timescale 1ns / 1ps
module segmenter_verdict_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	input  logic                             s_tready,
	input  logic [beus_pkg::SAMPLE_W-1:0]    s_tdata,  // [15:0] sample
	input  logic                             s_tlast,
	input  logic                             m_tvalid,
	input  logic                             m_tready,
	// [31:0] block_number, [74:32] block_energy, [75] is_speech, [76] utterance_opens,
	// [77] keep_block, [93:78] utterance_index, [109:94] pad_count, [141:110] kept_samples
	input  logic [beus_pkg::TDATA_OUT_W-1:0] m_tdata,
	input  logic                             m_tuser,  // [0] result_kind
	input  logic                             m_tlast,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [beus_pkg::ADDR_W-1:0]      paddr,
	input  logic [beus_pkg::DATA_W-1:0]      pwdata,
	input  logic                             pready,
	output int                               mismatches,
	output int                               results_due
);
	import beus_pkg::*;

	beus_res_t verdicts_due[$];

	logic [LEN_W-1:0]    cfg_len;
	logic [THR_W-1:0]    cfg_thr;
	logic [PAD_W-1:0]    cfg_pad;
	logic                cfg_split;
	logic                cfg_head_en;
	logic [HL_W-1:0]     cfg_head_samples;

	logic [ENERGY_W-1:0] energy_acc;
	logic [ENERGY_W-1:0] held_energy;
	int unsigned         block_pos;
	logic [NUM_W-1:0]    blocks_judged;
	logic                held_full;
	logic                head_hit;
	logic                utt_open;
	logic [UTT_W-1:0]    utt_made;
	logic [KEPT_W-1:0]   kept_total;

	function automatic longint unsigned block_size();
		if (cfg_len == '0)
			return 1;
		if (cfg_len > MAX_BLOCK_LEN)
			return MAX_BLOCK_LEN;
		return cfg_len;
	endfunction

	function automatic logic [PAD_W-1:0] pad_to_multiple(input logic [KEPT_W-1:0] kept);
		longint unsigned step;
		step = (cfg_pad == '0) ? 1 : cfg_pad;
		return PAD_W'((step - kept % step) % step);
	endfunction

	function automatic logic [UTT_W-1:0] open_index();
		return (utt_made != '0) ? utt_made - 1'b1 : '0;
	endfunction

	function automatic void clear_stream();
		energy_acc    = '0;
		held_energy   = '0;
		block_pos     = 0;
		blocks_judged = '0;
		held_full     = 1'b0;
		head_hit      = 1'b0;
		utt_open      = 1'b0;
		utt_made      = '0;
		kept_total    = '0;
	endfunction

	function automatic void judge_held();
		longint unsigned len;
		longint unsigned start;
		longint unsigned thr;
		longint unsigned grown;
		beus_res_t       r;
		len = block_size();
		start = blocks_judged * len;
		thr = cfg_thr;
		held_full = 1'b0;
		if (cfg_head_en && start >= cfg_head_samples) begin
			head_hit = 1'b1;
			return;
		end
		r = '0;
		r.kind = KIND_VERDICT;
		r.num = blocks_judged;
		r.energy = held_energy;
		if (blocks_judged != '1)
			blocks_judged++;
		r.speech = (held_energy >= thr * thr * len);
		if (r.speech) begin
			if (!utt_open) begin
				r.opens = 1'b1;
				utt_open = 1'b1;
				kept_total = '0;
				if (utt_made != '1)
					utt_made++;
			end
			r.keep = 1'b1;
			grown = kept_total + len;
			kept_total = (grown > 64'hFFFF_FFFF) ? '1 : KEPT_W'(grown);
			r.idx = open_index();
			r.kept = kept_total;
		end else if (utt_open) begin
			r.idx = open_index();
			r.kept = kept_total;
			if (cfg_split) begin
				r.closes = 1'b1;
				r.pad = pad_to_multiple(kept_total);
				utt_open = 1'b0;
			end
		end
		verdicts_due.push_back(r);
	endfunction

	function automatic void take_sample(input logic [SAMPLE_W-1:0] smp, input logic eos);
		beus_res_t         r;
		int                amp;
		logic [ENERGY_W:0] sum;
		if (eos) begin
			if (utt_open) begin
				r = '0;
				r.kind = KIND_CLOSE;
				r.closes = 1'b1;
				r.idx = open_index();
				r.pad = pad_to_multiple(kept_total);
				r.kept = kept_total;
				verdicts_due.push_back(r);
			end
			clear_stream();
			return;
		end
		if (head_hit)
			return;
		if (held_full) begin
			judge_held();
			if (head_hit)
				return;
		end
		amp = $signed(smp);
		sum = energy_acc + (ENERGY_W + 1)'(amp * amp);
		energy_acc = (sum > E_MAX) ? E_MAX : sum[ENERGY_W-1:0];
		block_pos++;
		if (block_pos >= block_size()) begin
			held_full = 1'b1;
			held_energy = energy_acc;
			energy_acc = '0;
			block_pos = 0;
		end
	endfunction

	function automatic void check_field(input string name, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			mismatches++;
			$error("%s: expected %0d, got %0d", name, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		beus_res_t want;
		beus_res_t got;
		if (!arst_n) begin
			cfg_len          = RST_BLOCK_LEN;
			cfg_thr          = RST_THRESHOLD;
			cfg_pad          = RST_PAD_LEN;
			cfg_split        = 1'b0;
			cfg_head_en      = 1'b0;
			cfg_head_samples = RST_HEAD_SAMPLES;
			clear_stream();
			verdicts_due.delete();
			mismatches = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.kind   = m_tuser;
				got.num    = m_tdata[31:0];
				got.energy = m_tdata[74:32];
				got.speech = m_tdata[75];
				got.opens  = m_tdata[76];
				got.keep   = m_tdata[77];
				got.idx    = m_tdata[93:78];
				got.pad    = m_tdata[109:94];
				got.kept   = m_tdata[141:110];
				got.closes = m_tlast;
				if (verdicts_due.size() == 0) begin
					mismatches++;
					$error("unexpected result: kind %0d block %0d", got.kind, got.num);
				end else begin
					want = verdicts_due.pop_front();
					check_field("result_kind", want.kind, got.kind);
					check_field("block_number", want.num, got.num);
					check_field("block_energy", want.energy, got.energy);
					check_field("is_speech", want.speech, got.speech);
					check_field("utterance_opens", want.opens, got.opens);
					check_field("keep_block", want.keep, got.keep);
					check_field("utterance_closes", want.closes, got.closes);
					check_field("utterance_index", want.idx, got.idx);
					check_field("pad_count", want.pad, got.pad);
					check_field("kept_samples", want.kept, got.kept);
				end
			end
			if (psel && penable && pwrite && pready) begin
				case (beus_reg_t'(paddr[4:2]))
					REG_BLOCK_LEN:    cfg_len = pwdata[LEN_W-1:0];
					REG_THRESHOLD:    cfg_thr = pwdata[THR_W-1:0];
					REG_PAD_LEN:      cfg_pad = pwdata[PAD_W-1:0];
					REG_SPLIT:        cfg_split = pwdata[0];
					REG_HEAD_EN:      cfg_head_en = pwdata[0];
					REG_HEAD_SAMPLES: cfg_head_samples = pwdata[HL_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				take_sample(s_tdata, s_tlast);
		end
		results_due = verdicts_due.size();
	end

endmodule

FILE: tb/block_energy_utterance_segmenter_tb.sv
// Testbench top for the block energy utterance segmenter: clock, reset, register setup,
// sample streams with random idling on both sides, and the verdict.
// Depends on beus_pkg, the segmenter RTL and segmenter_verdict_checker.
`timescale 1ns / 1ps
module block_energy_utterance_segmenter_tb;
	import beus_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 60;

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [SAMPLE_W-1:0]    s_tdata  = '0;
	logic                   s_tlast  = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [TDATA_OUT_W-1:0] m_tdata;
	logic                   m_tuser;
	logic                   m_tlast;
	logic                   psel     = 1'b0;
	logic                   penable  = 1'b0;
	logic                   pwrite   = 1'b0;
	logic [ADDR_W-1:0]      paddr    = '0;
	logic [DATA_W-1:0]      pwdata   = '0;
	logic [DATA_W-1:0]      prdata;
	logic                   pready;

	int mismatches;
	int results_due;
	int send_gap = 0;
	int recv_gap = 0;
	int quiet_cycles = 0;

	block_energy_utterance_segmenter i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	segmenter_verdict_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.pready      (pready),
		.mismatches  (mismatches),
		.results_due (results_due)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_gap);
	end

	// nothing moving on any port for too long ends the run
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	task automatic write_reg(input beus_reg_t which, input logic [DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {which, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
	endtask

	task automatic set_config(input int len, input int thr, input int pad, input int split,
			input int head_en, input int head_samples);
		write_reg(REG_BLOCK_LEN, len);
		write_reg(REG_THRESHOLD, thr);
		write_reg(REG_PAD_LEN, pad);
		write_reg(REG_SPLIT, split);
		write_reg(REG_HEAD_EN, head_en);
		write_reg(REG_HEAD_SAMPLES, head_samples);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic send_item(input logic [SAMPLE_W-1:0] smp, input logic eos);
		while ($urandom_range(99) < send_gap) begin
			s_tvalid <= 1'b0;
			s_tdata  <= SAMPLE_W'($urandom);
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= smp;
		s_tlast  <= eos;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (results_due != 0);
	endtask

	// streams of quiet and loud stretches; a stream ends on an end-of-stream request
	task automatic run_streams(input int items, input int run_lo, input int run_hi,
			input int quiet);
		int               left;
		bit               loud;
		logic [SAMPLE_W-1:0] smp;
		left = $urandom_range(run_hi, run_lo);
		loud = 1'b0;
		for (int n = 0; n < items; n++) begin
			if (n == items / 2)
				drain();
			if (left == 0) begin
				send_item(SAMPLE_W'($urandom), 1'b1);
				left = $urandom_range(run_hi, run_lo);
			end else begin
				if ($urandom_range(7) == 0)
					loud = !loud;
				smp = loud ? SAMPLE_W'($urandom) : SAMPLE_W'($urandom_range(2 * quiet) - quiet);
				send_item(smp, 1'b0);
				left--;
			end
		end
	endtask

	task automatic run_setting(input int s_gap, input int r_gap, input int len, input int thr,
			input int pad, input int split, input int head_en, input int head_samples,
			input int items, input int run_lo, input int run_hi, input int quiet);
		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
		send_gap = s_gap;
		recv_gap = r_gap;
		set_config(len, thr, pad, split, head_en, head_samples);
		run_streams(items, run_lo, run_hi, quiet);
	endtask

	initial begin : stimulus
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// two-sample blocks, threshold edge, split mode, pads to a multiple of three
		set_config(2, 100, 3, 1, 0, 80000);
		send_item(16'h0000, 1'b1);
		send_item(16'h7FFF, 1'b0);
		send_item(16'h8000, 1'b0);
		send_item(16'd100, 1'b0);
		send_item(16'd100, 1'b0);
		send_item(16'd100, 1'b0);
		send_item(16'd99, 1'b0);
		send_item(16'h0000, 1'b0);
		send_item(16'hFFFF, 1'b0);
		send_item(16'h0001, 1'b0);
		send_item(16'hFFFF, 1'b1);
		send_item(16'd5000, 1'b0);
		send_item(16'd5000, 1'b0);
		send_item(16'd5000, 1'b0);
		send_item(16'h5555, 1'b1);
		send_item(16'd5000, 1'b0);
		send_item(16'd5000, 1'b0);
		send_item(16'hAAAA, 1'b1);

		// head limit at three samples with one-sample blocks
		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
		set_config(1, 30, 4, 0, 1, 3);
		repeat (5) send_item(16'd1000, 1'b0);
		send_item(16'h0000, 1'b1);

		run_setting(0, 0, 3, 1000, 7, 1, 0, 80000, 150, 10, 80, 500);
		run_setting(64, 0, 1, 5000, 1, 0, 1, 40, 150, 20, 100, 3000);
		run_setting(0, 64, 0, 0, 0, 1, 0, 24'hFFFFFF, 120, 5, 60, 100);
		run_setting(17, 17, 5, 2000, 65535, 1, 1, 24'hFFFFFF, 150, 20, 150, 1500);
		run_setting(0, 64, 2, 32767, 2, 0, 1, 0, 60, 5, 30, 100);
		// oversized block length, left mid-block so the next setting shortens it
		run_setting(0, 0, 8191, 0, 3, 1, 0, 80000, 1000, 5000, 5000, 100);
		run_setting(17, 17, 3, 12000, 10, 1, 0, 80000, 150, 10, 100, 8000);
		run_setting(64, 0, 16, 3000, 100, 0, 1, 200, 150, 30, 300, 2000);

		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatches == 0 && results_due == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
